### hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

	// Number of entries the queue can hold.
	localparam int CAPACITY = 8;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int CMD_W    = 2;

	// Command codes; the unused codes two and three behave as a peek.
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Operation broadcast to every cell.
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_SHIFT  = 2'd2
	} cell_op_t;

	// Per-cell control from the top level.
	typedef struct packed {
		cell_op_t op;
		logic     occupied;
		logic     tail;
	} cell_ctrl_t;

endpackage

### hw/rtl/spq_cell.sv
// One compare-and-shift cell of the sorted queue chain.
module spq_cell (
	input  logic                          clk,
	input  spq_pkg::cell_ctrl_t           ctrl,
	input  logic [spq_pkg::VAL_W-1:0]     new_value,
	input  logic [spq_pkg::VAL_W-1:0]     left_value,
	input  logic                          left_gt,
	input  logic [spq_pkg::VAL_W-1:0]     right_value,
	output logic [spq_pkg::VAL_W-1:0]     value,
	output logic                          gt
);

	logic [spq_pkg::VAL_W-1:0] value_q;

	// The cell holds an entry larger than the incoming value.
	assign gt    = ctrl.occupied && ($signed(value_q) > $signed(new_value));
	assign value = value_q;

	// On insert, cells above the insertion point take their left neighbor's
	// entry and the insertion point takes the new value. On delete, every cell
	// but the last takes its right neighbor's entry; the last keeps its own.
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			spq_pkg::OP_INSERT: begin
				if (gt || ctrl.tail) begin
					value_q <= left_gt ? left_value : new_value;
				end
			end
			spq_pkg::OP_SHIFT: begin
				value_q <= right_value;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

endmodule

### hw/rtl/sorted_priority_queue.sv
// Sorted priority queue built from a chain of compare-and-shift cells.
// A result word appears on the master side in the cycle after its input word is accepted.
// One word per cycle while the master side does not stall; every cell compares and shifts in parallel.
// The output register frees the input side when empty or whenever the held result is taken in the same cycle.
// Reset clears the entry count and the output valid flag; cell contents stay undefined.
module sorted_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] result_value
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int N = spq_pkg::CAPACITY;
	localparam int W = spq_pkg::VAL_W;
	localparam int C = spq_pkg::CNT_W;

	logic [C-1:0]       count_q;
	logic               out_valid_q;
	logic [W-1:0]       out_value_q;
	spq_pkg::status_t   out_status_q;

	logic               in_acc;
	logic               is_insert;
	logic               is_delete;
	logic               full;
	logic               empty;
	spq_pkg::cell_op_t  op;
	spq_pkg::status_t   status;
	logic [W-1:0]       result;

	logic [W-1:0]       cell_value [N];
	logic               cell_gt    [N];

	// Handshake: the output register is free when empty or being drained.
	assign s_tready = !out_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_status_q;

	assign is_insert = (s_tuser == spq_pkg::CMD_INSERT);
	assign is_delete = (s_tuser == spq_pkg::CMD_DELETE);
	assign full      = (count_q == C'(N));
	assign empty     = (count_q == '0);

	// Decode the command into a chain operation and a result word.
	always_comb begin
		op     = spq_pkg::OP_HOLD;
		status = spq_pkg::ST_OK;
		result = '0;
		if (is_insert) begin
			if (full) begin
				status = spq_pkg::ST_FULL;
			end else begin
				result = s_tdata;
				op     = in_acc ? spq_pkg::OP_INSERT : spq_pkg::OP_HOLD;
			end
		end else if (empty) begin
			status = spq_pkg::ST_EMPTY;
		end else begin
			result = cell_value[0];
			if (is_delete && in_acc) begin
				op = spq_pkg::OP_SHIFT;
			end
		end
	end

	// The chain of cells, smallest entry in cell zero.
	for (genvar i = 0; i < N; i++) begin : g_cell
		localparam logic [C-1:0] IDX = C'(i);
		spq_pkg::cell_ctrl_t ctrl;
		logic [W-1:0]        left_value;
		logic                left_gt;
		logic [W-1:0]        right_value;

		assign ctrl.op       = op;
		assign ctrl.occupied = (IDX < count_q);
		assign ctrl.tail     = (IDX == count_q);

		if (i == 0) begin : g_first
			assign left_value = s_tdata;
			assign left_gt    = 1'b0;
		end else begin : g_inner
			assign left_value = cell_value[i-1];
			assign left_gt    = cell_gt[i-1];
		end

		if (i == N - 1) begin : g_last
			assign right_value = cell_value[i];
		end else begin : g_mid
			assign right_value = cell_value[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.new_value   (s_tdata),
			.left_value  (left_value),
			.left_gt     (left_gt),
			.right_value (right_value),
			.value       (cell_value[i]),
			.gt          (cell_gt[i])
		);
	end

	// Entry count tracks successful inserts and deletes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op == spq_pkg::OP_INSERT) begin
			count_q <= count_q + C'(1);
		end else if (op == spq_pkg::OP_SHIFT) begin
			count_q <= count_q - C'(1);
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_value_q  <= result;
			out_status_q <= status;
		end
	end

`ifndef SYNTHESIS
	// The entry count never passes the capacity.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= C'(N))
		else $error("entry count above capacity");

	// A successful insert grows the queue by exactly one entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_insert && !full |=> count_q == $past(count_q) + C'(1))
		else $error("insert did not add one entry");

	// A delete on a non-empty queue shrinks it by exactly one entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_delete && !empty |=> count_q == $past(count_q) - C'(1))
		else $error("delete did not remove one entry");

	// Occupied neighbors stay in ascending order.
	for (genvar k = 0; k < N - 1; k++) begin : g_order_chk
		assert property (@(posedge clk) disable iff (!arst_n)
			(C'(k + 1) < count_q) |-> ($signed(cell_value[k]) <= $signed(cell_value[k+1])))
			else $error("queue entries out of order");
	end
`endif

endmodule
